// ===== hdl/ica_pkg.sv =====
// ----------------------------------------------------------------------------
// ica_pkg
// Types, codes and helper functions shared by the integer calculator cells
// and the top level.
// ----------------------------------------------------------------------------
package ica_pkg;

   localparam int DataWidth = 32;
   localparam int CellCount = DataWidth;
   localparam int IdxWidth  = $clog2(CellCount);
   localparam int SqrtSteps = DataWidth / 2;

   typedef logic [DataWidth-1:0]   data_type;
   typedef logic [2*DataWidth-1:0] wide_type;
   typedef logic [IdxWidth-1:0]    idx_type;

   // opcodes
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_MUL  = 3'd3;
   localparam logic [2:0] OP_DIV  = 3'd4;
   localparam logic [2:0] OP_SQR  = 3'd5;
   localparam logic [2:0] OP_ROOT = 3'd6;
   localparam logic [2:0] OP_POW  = 3'd7;

   // status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_OVF     = 3'd1;
   localparam logic [2:0] ST_DIV0    = 3'd2;
   localparam logic [2:0] ST_NEGROOT = 3'd3;
   localparam logic [2:0] ST_BADOP   = 3'd4;

   // what the cells do with a word
   typedef enum logic [1:0] {
      K_FIXED,
      K_MULPOW,
      K_DIV,
      K_SQRT
   } kind_type;

   // one word traveling down the chain of cells
   typedef struct packed {
      logic     valid;
      kind_type kind;
      logic [2:0] st;
      logic     neg;
      data_type acc;     // product magnitude, remainder
      data_type aux;     // base magnitude, divisor, root
      data_type work;    // exponent bits, dividend or radicand bits
      data_type quo;     // quotient or finished result
      logic     big_r;   // true product magnitude has left the word
      logic     big_b;   // true base magnitude has left the word
   } word_type;

   function automatic data_type mag(data_type v);
      return v[DataWidth-1] ? data_type'(-v) : v;
   endfunction

   // largest magnitude a result of the given sign may have
   function automatic data_type mag_limit(logic neg);
      return {neg, {(DataWidth-1){~neg}}};
   endfunction

   // decode one request into the word that enters the first cell
   function automatic word_type setup(logic [2:0] op, data_type a, data_type b);
      word_type w;
      data_type sum;
      data_type one;
      w    = '0;
      sum  = '0;
      one  = data_type'(1);
      w.kind = K_FIXED;
      w.st   = ST_OK;
      case (op)
         OP_ADD: begin
            sum   = a + b;
            w.quo = sum;
            if (a[DataWidth-1] == b[DataWidth-1] && sum[DataWidth-1] != a[DataWidth-1])
               w.st = ST_OVF;
         end
         OP_SUB: begin
            sum   = a - b;
            w.quo = sum;
            if (a[DataWidth-1] != b[DataWidth-1] && sum[DataWidth-1] != a[DataWidth-1])
               w.st = ST_OVF;
         end
         OP_MUL: begin
            w.kind = K_MULPOW;
            w.acc  = mag(a);
            w.aux  = mag(b);
            w.work = one;
            w.neg  = a[DataWidth-1] ^ b[DataWidth-1];
         end
         OP_SQR: begin
            w.kind = K_MULPOW;
            w.acc  = mag(a);
            w.aux  = mag(a);
            w.work = one;
         end
         OP_DIV: begin
            if (b == '0) begin
               w.st = ST_DIV0;
            end else begin
               w.kind = K_DIV;
               w.aux  = mag(b);
               w.work = mag(a);
               w.neg  = a[DataWidth-1] ^ b[DataWidth-1];
            end
         end
         OP_ROOT: begin
            if (a[DataWidth-1]) begin
               w.st = ST_NEGROOT;
            end else begin
               w.kind = K_SQRT;
               w.work = a;
            end
         end
         OP_POW: begin
            if (b[DataWidth-1]) begin
               if (a == one)
                  w.quo = one;
               else if (a == '1)
                  w.quo = b[0] ? '1 : one;
               else if (a == '0)
                  w.st = ST_DIV0;
            end else begin
               w.kind = K_MULPOW;
               w.acc  = one;
               w.aux  = mag(a);
               w.work = b;
               w.neg  = a[DataWidth-1] & b[0];
            end
         end
         default: begin
            w.st = ST_BADOP;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/ica_cell.sv =====
// ----------------------------------------------------------------------------
// ica_cell
// One cell of the calculator chain: one exponent bit of square-and-multiply,
// one quotient bit of restoring division, or, in the first half of the chain, one root bit of the square root.
// ----------------------------------------------------------------------------
module ica_cell
   import ica_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  idx_type  cell_idx,
   input  word_type prev_word,
   output word_type word_out
);

   word_type word_ff;
   word_type word_in;
   wide_type prod_r;
   wide_type prod_b;
   data_type rem_sh;
   data_type rem_sq;
   data_type trial;
   logic     sqrt_active;

   assign prod_r      = wide_type'(prev_word.acc) * wide_type'(prev_word.aux);
   assign prod_b      = wide_type'(prev_word.aux) * wide_type'(prev_word.aux);
   assign rem_sh      = {prev_word.acc[DataWidth-2:0], prev_word.work[DataWidth-1]};
   assign rem_sq      = {prev_word.acc[DataWidth-3:0], prev_word.work[DataWidth-1 -: 2]};
   assign trial       = {prev_word.aux[DataWidth-3:0], 2'b01};
   assign sqrt_active = cell_idx < idx_type'(SqrtSteps);

   // work out one step of this word
   always_comb begin
      word_in = prev_word;
      case (prev_word.kind)
         K_MULPOW: begin
            if (prev_word.work[0]) begin
               word_in.acc   = prod_r[DataWidth-1:0];
               word_in.big_r = prev_word.big_r | prev_word.big_b
                               | (|prod_r[2*DataWidth-1:DataWidth]);
            end
            word_in.aux   = prod_b[DataWidth-1:0];
            word_in.big_b = prev_word.big_b | (|prod_b[2*DataWidth-1:DataWidth]);
            word_in.work  = prev_word.work >> 1;
         end
         K_DIV: begin
            if (rem_sh >= prev_word.aux) begin
               word_in.acc = rem_sh - prev_word.aux;
               word_in.quo = {prev_word.quo[DataWidth-2:0], 1'b1};
            end else begin
               word_in.acc = rem_sh;
               word_in.quo = {prev_word.quo[DataWidth-2:0], 1'b0};
            end
            word_in.work = prev_word.work << 1;
         end
         K_SQRT: begin
            if (sqrt_active) begin
               if (rem_sq >= trial) begin
                  word_in.acc = rem_sq - trial;
                  word_in.aux = {prev_word.aux[DataWidth-2:0], 1'b1};
               end else begin
                  word_in.acc = rem_sq;
                  word_in.aux = {prev_word.aux[DataWidth-2:0], 1'b0};
               end
               word_in.work = prev_word.work << 2;
            end
         end
         default: begin
         end
      endcase
   end

   // advance the word when the chain moves
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (advance) begin
         word_ff <= word_in;
      end
   end

   assign word_out = word_ff;

endmodule

// ===== hdl/integer_calculator_alu.sv =====
// ----------------------------------------------------------------------------
// integer_calculator_alu
// Signed integer add, subtract, multiply, divide, square, square root and
// power, one request word per cycle while the response is not stalled, through a chain of cells.
// ----------------------------------------------------------------------------
// A request word is taken every cycle that the output is free or being taken;
// its response passes through the chain of cells, each of which works one
// exponent or quotient bit (or, in the first half of the chain, one root bit), and then the response register.
// Words stay in order; a stalled response holds the whole chain.
module integer_calculator_alu
   import ica_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [2:0]     req_op,
   input  logic signed [DataWidth-1:0] req_operand_a,
   input  logic signed [DataWidth-1:0] req_operand_b,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic signed [DataWidth-1:0] rsp_result,
   output logic [2:0]     rsp_status
);

   word_type chain [CellCount+1];
   word_type last;
   logic     advance;
   logic     rsp_valid_ff;
   data_type rsp_result_ff;
   data_type rsp_result_in;
   logic [2:0] rsp_status_ff;
   logic [2:0] rsp_status_in;
   data_type fin_mag;

   assign advance   = ~rsp_valid_ff | rsp_ready;
   assign req_ready = advance;

   // decode the request into the first word
   always_comb begin
      chain[0]       = setup(req_op, data_type'(req_operand_a), data_type'(req_operand_b));
      chain[0].valid = req_valid;
   end

   for (genvar i = 0; i < CellCount; i++) begin : g_cell
      ica_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .cell_idx  (idx_type'(i)),
         .prev_word (chain[i]),
         .word_out  (chain[i+1])
      );
   end

   assign last = chain[CellCount];

   // finish: sign and range check
   always_comb begin
      fin_mag       = '0;
      rsp_result_in = last.quo;
      rsp_status_in = last.st;
      case (last.kind)
         K_MULPOW: begin
            fin_mag       = last.acc;
            rsp_result_in = last.neg ? data_type'(-fin_mag) : fin_mag;
            if (last.big_r || fin_mag > mag_limit(last.neg))
               rsp_status_in = ST_OVF;
         end
         K_DIV: begin
            fin_mag       = last.quo;
            rsp_result_in = last.neg ? data_type'(-fin_mag) : fin_mag;
            if (fin_mag > mag_limit(last.neg))
               rsp_status_in = ST_OVF;
         end
         K_SQRT: begin
            rsp_result_in = last.aux;
         end
         default: begin
         end
      endcase
   end

   // hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff  <= last.valid;
         rsp_result_ff <= rsp_result_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_status = rsp_status_ff;

`ifndef NO_ASSERTIONS
   a_status_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_BADOP)
      else $error("status code out of range");

   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_DIV0 || rsp_status == ST_NEGROOT ||
                    rsp_status == ST_BADOP) |-> rsp_result == '0)
      else $error("error response carries nonzero result");

   a_stall_blocks : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule
